FILE: design/clm_pkg.sv
// clm_pkg: shared types, constants and the class rule function
// for the collision layer mapper; no dependencies
package clm_pkg;

    localparam int TABLE_DEPTH = 8192;
    localparam int ID_W        = 13;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_CLASSES = 5;

    typedef enum logic [1:0] {
        K_MAP    = 2'd0,
        K_DECODE = 2'd1,
        K_PAIR   = 2'd2,
        K_PHASE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_OK        = 2'd0,
        S_FULL      = 2'd1,
        S_NOT_ALLOC = 2'd2
    } t_status;

    // queued command, as classified by the front end
    typedef struct packed {
        t_kind            kind;
        logic [2:0]       pclass;
        logic [63:0]      key;
        logic [ID_W-1:0]  id_a;
        logic [2:0]       cls_a;
        logic [ID_W-1:0]  id_b;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        t_cmd        cmd;
    } t_head;

    typedef struct packed {
        logic [15:0] enc;
        logic [2:0]  cls;
        logic [31:0] lay;
        logic [31:0] msk;
        logic        col;
        t_status     st;
    } t_res;

    localparam logic [NUM_CLASSES-1:0] BASE_RULES [NUM_CLASSES] =
        '{5'h04, 5'h04, 5'h1F, 5'h1C, 5'h0C};
    localparam logic [NUM_CLASSES-1:0] STATIC_RULES [NUM_CLASSES] =
        '{5'h18, 5'h18, 5'h00, 5'h03, 5'h03};

    // broad-phase class matrix lookup
    function automatic logic class_allowed(input logic [2:0] c1, input logic [2:0] c2,
                                           input logic see_static);
        logic [NUM_CLASSES-1:0] row;
        row = '0;
        if (c1 < 3'(NUM_CLASSES) && c2 < 3'(NUM_CLASSES)) begin
            row = BASE_RULES[c1];
            if (see_static) begin
                row = row | STATIC_RULES[c1];
            end
            return row[c2];
        end
        return 1'b0;
    endfunction

endpackage

FILE: design/clm_front.sv
// clm_front: accepts input transfers, classifies them into commands
// and holds them in a two-entry queue; depends on clm_pkg
module clm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_kind,
    input  logic [2:0]          i_phase_class,
    input  logic [31:0]         i_layer_bits,
    input  logic [31:0]         i_mask_bits,
    input  logic [15:0]         i_encoded_a,
    input  logic [15:0]         i_encoded_b,
    input  logic                i_pop,
    output clm_pkg::t_head      o_head
);
    import clm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    // classify the incoming transfer
    always_comb begin
        w_cmd.kind   = t_kind'(i_kind);
        w_cmd.pclass = i_phase_class;
        w_cmd.key    = {i_layer_bits, i_mask_bits};
        w_cmd.id_a   = i_encoded_a[ID_W-1:0];
        w_cmd.cls_a  = i_encoded_a[15:ID_W];
        w_cmd.id_b   = i_encoded_b[ID_W-1:0];
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

FILE: design/clm_back.sv
// clm_back: executes queued commands against the key store and
// drives the output register; depends on clm_pkg
module clm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  clm_pkg::t_head      i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clm_pkg::t_res       o_res
);
    import clm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_RDA  = 6'b000100,
        ST_RDB  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic               r_cmp_v, n_cmp_v;
    logic               r_see_static;
    logic [63:0]        r_key_a, n_key_a;
    t_res               r_res, n_res;
    t_res               r_out;
    logic               r_out_valid;
    logic [63:0]        r_mem [TABLE_DEPTH];
    logic [63:0]        r_rdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic               w_issue;
    logic               ok_a, ok_b;
    logic [63:0]        key_a, key_b;
    logic               w_load;

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
    assign w_load      = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign w_issue     = (r_state == ST_SCAN) && (r_idx < r_used);

    // lookup validity of the two ids
    assign ok_a = 32'(r_cmd.id_a) < 32'(r_used);
    assign ok_b = 32'(r_cmd.id_b) < 32'(r_used);
    // id 0 holds key zero from reset and is never written
    assign key_a = (!ok_a || r_cmd.id_a == '0) ? 64'd0 : r_key_a;
    assign key_b = (!ok_b || r_cmd.id_b == '0) ? 64'd0 : r_rdata;

    // read address selection
    always_comb begin
        unique case (r_state)
            ST_RDA:  w_raddr = r_cmd.id_a[ADDR_W-1:0];
            ST_RDB:  w_raddr = r_cmd.id_b[ADDR_W-1:0];
            default: w_raddr = r_idx[ADDR_W-1:0];
        endcase
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_cmd.key;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_idx     = r_idx;
        n_cmp_idx = r_idx;
        n_cmp_v   = w_issue;
        n_key_a   = r_key_a;
        n_res     = r_res;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_used[ADDR_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_res   = '0;
                    n_idx   = CNT_W'(1);
                    n_cmp_v = 1'b0;
                    unique case (i_head.cmd.kind)
                        K_MAP: begin
                            if (i_head.cmd.key == 64'd0) begin
                                n_res.enc = {i_head.cmd.pclass, {ID_W{1'b0}}};
                                n_state   = ST_OUT;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        K_DECODE, K_PAIR: n_state = ST_RDA;
                        default: begin
                            n_res.col = class_allowed(i_head.cmd.cls_a, i_head.cmd.pclass,
                                                      r_see_static);
                            n_state   = ST_OUT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_issue) n_idx = r_idx + CNT_W'(1);
                if (r_cmp_v && r_rdata == r_cmd.key) begin
                    n_res.enc = {r_cmd.pclass, ID_W'(r_cmp_idx)};
                    n_state   = ST_OUT;
                end else if (!r_cmp_v && !w_issue) begin
                    // no match: allocate or report full
                    if (r_used == CNT_W'(TABLE_DEPTH)) begin
                        n_res.st = S_FULL;
                    end else begin
                        w_we      = 1'b1;
                        n_res.enc = {r_cmd.pclass, ID_W'(r_used)};
                        n_used    = r_used + CNT_W'(1);
                    end
                    n_state = ST_OUT;
                end
            end
            ST_RDA: n_state = ST_RDB;
            ST_RDB: begin
                n_key_a = r_rdata;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (r_cmd.kind == K_DECODE) begin
                    n_res.cls = r_cmd.cls_a;
                    n_res.lay = key_a[63:32];
                    n_res.msk = key_a[31:0];
                    n_res.st  = ok_a ? S_OK : S_NOT_ALLOC;
                end else begin
                    n_res.col = ((key_a[31:0] & key_b[63:32]) != '0) ||
                                ((key_b[31:0] & key_a[63:32]) != '0);
                    n_res.st  = (ok_a && ok_b) ? S_OK : S_NOT_ALLOC;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_key_a   <= n_key_a;
        r_res     <= n_res;
        if (o_pop) r_cmd <= i_head.cmd;
        if (w_load) r_out <= r_res;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_used       <= CNT_W'(1);
            r_cmp_v      <= 1'b0;
            r_see_static <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_cmp_v <= n_cmp_v;
            if (i_cfg_wr_en) r_see_static <= i_cfg_wr_data;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: design/collision_layer_mapper.sv
// collision_layer_mapper: top level joining the command queue front end
// and the key store back end; depends on clm_pkg, clm_front, clm_back
//
//  channel   handshake                    payload
//  in        i_in_valid / o_in_ready      i_kind .. i_encoded_b
//  out       o_out_valid / i_out_ready    o_encoded_out .. o_status
//  config    i_cfg_wr_en                  i_cfg_wr_data
//
// map scans the key store one entry per cycle through its single read port;
// a zero key answers without a scan.
// decode and pair test make two store reads, the broad-phase test none.
// reset is synchronous; the store needs no clearing pass.
// two queued commands decouple input stalls from output stalls.
module collision_layer_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_phase_class,
    input  logic [31:0] i_layer_bits,
    input  logic [31:0] i_mask_bits,
    input  logic [15:0] i_encoded_a,
    input  logic [15:0] i_encoded_b,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_encoded_out,
    output logic [2:0]  o_class_out,
    output logic [31:0] o_layer_out,
    output logic [31:0] o_mask_out,
    output logic        o_collide,
    output logic [1:0]  o_status
);
    import clm_pkg::*;

    t_head w_head;
    logic  w_pop;
    t_res  w_res;

    // front end: accept and queue
    clm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_phase_class (i_phase_class),
        .i_layer_bits  (i_layer_bits),
        .i_mask_bits   (i_mask_bits),
        .i_encoded_a   (i_encoded_a),
        .i_encoded_b   (i_encoded_b),
        .i_pop         (w_pop),
        .o_head        (w_head)
    );

    // back end: execute and deliver
    clm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_res         (w_res)
    );

    assign o_encoded_out = w_res.enc;
    assign o_class_out   = w_res.cls;
    assign o_layer_out   = w_res.lay;
    assign o_mask_out    = w_res.msk;
    assign o_collide     = w_res.col;
    assign o_status      = w_res.st;

endmodule

FILE: tb/sv/collision_layer_mapper_tb.sv
// collision_layer_mapper_tb: self-checking bench for the collision layer mapper
// keeps its own key table and class matrix to predict every answer;
// depends on clm_pkg and collision_layer_mapper
`timescale 1ns / 100ps

module collision_layer_mapper_tb;
    import clm_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [2:0]  i_phase_class;
    logic [31:0] i_layer_bits;
    logic [31:0] i_mask_bits;
    logic [15:0] i_encoded_a;
    logic [15:0] i_encoded_b;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_encoded_out;
    logic [2:0]  o_class_out;
    logic [31:0] o_layer_out;
    logic [31:0] o_mask_out;
    logic        o_collide;
    logic [1:0]  o_status;

    // predictor state
    logic [63:0] key_table [TABLE_DEPTH];
    int          ids_used;
    logic        see_static;

    t_res        pending_answers [$];
    int          errors;
    int          answers_seen;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    collision_layer_mapper DUT (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            answers_seen <= answers_seen + 1;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result enc=%h", $time, o_encoded_out);
                errors <= errors + 1;
            end else begin
                want = pending_answers.pop_front();
                if (o_encoded_out !== want.enc || o_class_out !== want.cls ||
                    o_layer_out !== want.lay || o_mask_out !== want.msk ||
                    o_collide !== want.col || o_status !== want.st) begin
                    $display("%0t: expected enc=%h cls=%0d lay=%h msk=%h col=%b st=%0d",
                             $time, want.enc, want.cls, want.lay, want.msk,
                             want.col, want.st);
                    $display("%0t: actual   enc=%h cls=%0d lay=%h msk=%h col=%b st=%0d",
                             $time, o_encoded_out, o_class_out, o_layer_out,
                             o_mask_out, o_collide, o_status);
                    errors <= errors + 1;
                end
            end
        end
    end

    // matrix rule of the broad phase
    function automatic logic phase_rule(input logic [2:0] c1, input logic [2:0] c2);
        logic [4:0] base_row [5];
        logic [4:0] extra_row [5];
        logic [4:0] row;
        base_row  = '{5'h04, 5'h04, 5'h1F, 5'h1C, 5'h0C};
        extra_row = '{5'h18, 5'h18, 5'h00, 5'h03, 5'h03};
        if (c1 > 3'd4 || c2 > 3'd4) return 1'b0;
        row = base_row[c1];
        if (see_static) row = row | extra_row[c1];
        return row[c2];
    endfunction

    // predict the answer to one command, updating the table
    function automatic t_res predict_answer(input t_kind kind, input logic [2:0] pc,
                                            input logic [31:0] lay, input logic [31:0] msk,
                                            input logic [15:0] ea, input logic [15:0] eb);
        t_res        r;
        logic [63:0] key;
        logic [63:0] ka;
        logic [63:0] kb;
        int          id;
        logic        hit;
        r = '0;
        r.st = S_OK;
        case (kind)
            K_MAP: begin
                key = {lay, msk};
                hit = 1'b0;
                id = 0;
                for (int i = 0; i < ids_used; i++) begin
                    if (!hit && key_table[i] == key) begin
                        hit = 1'b1;
                        id = i;
                    end
                end
                if (!hit) begin
                    if (ids_used >= TABLE_DEPTH) begin
                        r.st = S_FULL;
                    end else begin
                        id = ids_used;
                        key_table[id] = key;
                        ids_used++;
                        hit = 1'b1;
                    end
                end
                if (hit) r.enc = {pc, id[12:0]};
            end
            K_DECODE: begin
                r.cls = ea[15:13];
                if (int'(ea[12:0]) < ids_used) begin
                    r.lay = key_table[ea[12:0]][63:32];
                    r.msk = key_table[ea[12:0]][31:0];
                end else begin
                    r.st = S_NOT_ALLOC;
                end
            end
            K_PAIR: begin
                ka = (int'(ea[12:0]) < ids_used) ? key_table[ea[12:0]] : 64'd0;
                kb = (int'(eb[12:0]) < ids_used) ? key_table[eb[12:0]] : 64'd0;
                r.col = ((ka[31:0] & kb[63:32]) != 0) || ((kb[31:0] & ka[63:32]) != 0);
                if (int'(ea[12:0]) >= ids_used || int'(eb[12:0]) >= ids_used)
                    r.st = S_NOT_ALLOC;
            end
            default: begin
                r.col = phase_rule(ea[15:13], pc);
            end
        endcase
        return r;
    endfunction

    // send one command and queue its answer; valid stays up for a following
    // transfer and drops only while the sender idles
    task automatic send_command(input t_kind kind, input logic [2:0] pc,
                                input logic [31:0] lay, input logic [31:0] msk,
                                input logic [15:0] ea, input logic [15:0] eb);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_phase_class <= pc;
        i_layer_bits  <= lay;
        i_mask_bits   <= msk;
        i_encoded_a   <= ea;
        i_encoded_b   <= eb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_answers.push_back(predict_answer(kind, pc, lay, msk, ea, eb));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_see_static(input logic value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        see_static    = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // pick an id that is allocated, or now and then any id in the 13-bit range
    function automatic logic [15:0] pick_encoded();
        logic [12:0] id;
        if ($urandom_range(9) == 0) id = 13'($urandom);
        else id = 13'($urandom_range(ids_used - 1));
        return {3'($urandom), id};
    endfunction

    task automatic test_directed();
        send_command(K_DECODE, 3'd0, '0, '0, 16'h0000, 16'h0);
        send_command(K_MAP, 3'd0, '0, '0, '0, '0);
        send_command(K_MAP, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
        send_command(K_MAP, 3'd4, 32'h0000_0001, 32'h8000_0000, '0, '0);
        send_command(K_MAP, 3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
        send_command(K_DECODE, 3'd0, '0, '0, 16'hE001, '0);
        send_command(K_DECODE, 3'd0, '0, '0, 16'h3FFF, '0);
        send_command(K_DECODE, 3'd0, '0, '0, 16'h0003, '0);
        send_command(K_PAIR, 3'd0, '0, '0, 16'h0001, 16'h0002);
        send_command(K_PAIR, 3'd0, '0, '0, 16'h0000, 16'h0001);
        send_command(K_PAIR, 3'd0, '0, '0, 16'h1FFF, 16'h0001);
        send_command(K_PHASE, 3'd5, '0, '0, 16'h4000, '0);
        send_command(K_PHASE, 3'd3, '0, '0, 16'hE000, '0);
        for (int a = 0; a < 5; a++)
            send_command(K_PHASE, 3'(a), '0, '0, {3'(4 - a), 13'd0}, '0);
    endtask

    task automatic test_matrix(input logic value);
        write_see_static(value);
        for (int a = 0; a < 8; a++)
            for (int b = 0; b < 8; b++)
                send_command(K_PHASE, 3'(b), '0, '0, {3'(a), 13'($urandom)}, '0);
    endtask

    task automatic test_random(input int count);
        t_kind       kind;
        logic [31:0] lay;
        logic [31:0] msk;
        logic [63:0] old;
        for (int n = 0; n < count; n++) begin
            kind = t_kind'($urandom_range(3));
            lay = $urandom;
            msk = $urandom;
            // repeat a stored key now and then
            if (kind == K_MAP && $urandom_range(1) == 0) begin
                old = key_table[$urandom_range(ids_used - 1)];
                lay = old[63:32];
                msk = old[31:0];
            end
            if (n == count / 2) begin
                // hold until everything has drained
                wait_drained();
            end
            send_command(kind, 3'($urandom), lay, msk, pick_encoded(), pick_encoded());
        end
    endtask

    task automatic test_idling();
        int stall_mix [4][2];
        stall_mix = '{'{0, 0}, '{46, 0}, '{0, 46}, '{20, 20}};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = stall_mix[p][0];
            recv_stall_pct = stall_mix[p][1];
            test_random(200);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        cycles = 0;
        errors = 0;
        answers_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ids_used = 1;
        see_static = 1'b0;
        key_table[0] = 64'd0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_in_valid = 1'b0;
        i_kind = K_MAP;
        i_phase_class = '0;
        i_layer_bits = '0;
        i_mask_bits = '0;
        i_encoded_a = '0;
        i_encoded_b = '0;
        i_out_ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_matrix(1'b1);
        test_idling();
        test_matrix(1'b0);
        write_see_static(1'b1);
        test_random(20);

        wait_drained();
        $display("covered map, decode, pair and class tests under both matrix settings");
        $display("%0d answers checked, %0d ids in use, %0d errors",
                 answers_seen, ids_used, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
